@@ rtl/core/fcp_pkg.sv @@
// Shared types and constants of the framed CSV command parser.
`default_nettype none

package fcp_pkg;

  localparam int unsigned NumFields = 5;
  localparam int unsigned FieldIdxW = 3;
  localparam int unsigned BodyLenW  = 6;
  localparam int unsigned CfgIdxW   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_BYTE = 2'd0,
    CFG_END_BYTE   = 2'd1,
    CFG_SEP_BYTE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_WRONG_START = 3'd1,
    ST_WRONG_END   = 3'd2,
    ST_TIMEOUT     = 3'd3,
    ST_MISSING     = 3'd4
  } status_e;

  localparam logic [7:0] StartByteRst = 8'd126;
  localparam logic [7:0] EndByteRst   = 8'd42;
  localparam logic [7:0] SepByteRst   = 8'd44;

  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharNine  = 8'd57;
  localparam logic [7:0] CharPlus  = 8'd43;
  localparam logic [7:0] CharMinus = 8'd45;
  localparam logic [7:0] CharSpace = 8'd32;
  localparam logic [7:0] CharTab   = 8'd9;
  localparam logic [7:0] CharCr    = 8'd13;

  typedef struct packed {
    status_e                   status;
    logic [NumFields-1:0][7:0] values;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/framed_csv_command_parser.sv @@
// Top level of the framed CSV command parser: frame tracking, field parsing, result buffering.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+------------------------------------------
//   in      | input     | in_valid_i / in_stall_o | rx_byte_i, is_timeout_i
//   out     | output    | out_valid_o / out_stall_i | status_o, motor_id_o .. speed_o
//   cfg     | input     | cfg_we_i               | cfg_index_i, cfg_data_i
//
// Each item is fully processed in the cycle it is accepted; one item per cycle unless stalled.
// Its result is registered in the output register, or in the skid register if that is held.
// A two-entry output buffer (output register plus skid register) decouples the sides;
// in_stall_o rises only when both entries hold results.
// Reset restores the default frame bytes and returns the parser to idle.
`default_nettype none

module framed_csv_command_parser #(
  parameter int unsigned MAX_BODY = 49
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [7:0]                  rx_byte_i,
  input  wire logic                        is_timeout_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [2:0]                       status_o,
  output logic [7:0]                       motor_id_o,
  output logic [7:0]                       motor_state_o,
  output logic [7:0]                       direction_o,
  output logic [7:0]                       step_count_o,
  output logic [7:0]                       speed_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [fcp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                  cfg_data_i
);

  localparam logic [fcp_pkg::BodyLenW-1:0]  MaxBodyLen = fcp_pkg::BodyLenW'(MAX_BODY);
  localparam logic [fcp_pkg::FieldIdxW-1:0] FieldsFull = fcp_pkg::FieldIdxW'(fcp_pkg::NumFields);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_FULL = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    NP_BETWEEN = 2'd0,
    NP_LEAD    = 2'd1,
    NP_DIGITS  = 2'd2,
    NP_TRAIL   = 2'd3
  } num_phase_e;

  logic [7:0] start_q, end_q, sep_q;

  phase_e                          phase_q, phase_d;
  logic [fcp_pkg::BodyLenW-1:0]    body_len_q, body_len_d;
  logic [fcp_pkg::FieldIdxW-1:0]   fidx_q, fidx_d;
  num_phase_e                      nph_q, nph_d;
  logic                            neg_q, neg_d;
  logic [7:0]                      acc_q, acc_d;
  logic                            ended_q, ended_d;
  logic [fcp_pkg::NumFields-1:0][7:0] fields_q, fields_d;

  fcp_pkg::result_t res;
  logic             res_valid;
  fcp_pkg::result_t out_q, skid_q;
  logic             out_valid_q, skid_valid_q;

  logic                          in_acc;
  logic                          out_pop;
  logic [7:0]                    close_val;
  logic [3:0]                    digit;
  logic [7:0]                    acc_x10;
  logic                          is_digit;
  logic                          is_ws;
  logic                          do_close;
  logic [fcp_pkg::FieldIdxW-1:0] fidx_fin;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_pop    = out_valid_q && !out_stall_i;

  assign close_val = neg_q ? 8'(8'd0 - acc_q) : acc_q;
  assign digit     = 4'(rx_byte_i - fcp_pkg::CharZero);
  assign acc_x10   = 8'({acc_q[4:0], 3'b000} + {acc_q[6:0], 1'b0});
  assign is_digit  = rx_byte_i inside {[fcp_pkg::CharZero:fcp_pkg::CharNine]};
  assign is_ws     = rx_byte_i inside {fcp_pkg::CharSpace, [fcp_pkg::CharTab:fcp_pkg::CharCr]};

  always_comb begin
    phase_d    = phase_q;
    body_len_d = body_len_q;
    fidx_d     = fidx_q;
    nph_d      = nph_q;
    neg_d      = neg_q;
    acc_d      = acc_q;
    ended_d    = ended_q;
    fields_d   = fields_q;
    res_valid  = 1'b0;
    res        = '0;
    do_close   = 1'b0;
    fidx_fin   = fidx_q;

    if (in_acc) begin
      if (phase_q == PH_IDLE) begin
        if (!is_timeout_i) begin
          if (rx_byte_i != start_q) begin
            res_valid  = 1'b1;
            res.status = fcp_pkg::ST_WRONG_START;
          end else begin
            phase_d    = PH_BODY;
            body_len_d = '0;
            fidx_d     = '0;
            nph_d      = NP_BETWEEN;
            neg_d      = 1'b0;
            acc_d      = '0;
            ended_d    = 1'b0;
          end
        end
      end else if (is_timeout_i) begin
        phase_d    = PH_IDLE;
        res_valid  = 1'b1;
        res.status = fcp_pkg::ST_TIMEOUT;
      end else if (rx_byte_i == end_q) begin
        phase_d   = PH_IDLE;
        res_valid = 1'b1;
        if (!ended_q && nph_q != NP_BETWEEN && fidx_q < FieldsFull) begin
          fields_d[fidx_q] = close_val;
          fidx_fin         = fidx_q + 1'b1;
        end
        if (fidx_fin >= FieldsFull) begin
          res.status = fcp_pkg::ST_OK;
          res.values = fields_d;
        end else begin
          res.status = fcp_pkg::ST_MISSING;
        end
      end else if (phase_q == PH_FULL) begin
        phase_d    = PH_IDLE;
        res_valid  = 1'b1;
        res.status = fcp_pkg::ST_WRONG_END;
      end else begin
        if (!ended_q) begin
          if (rx_byte_i == 8'd0) begin
            do_close = 1'b1;
            ended_d  = 1'b1;
          end else if (rx_byte_i == sep_q) begin
            do_close = 1'b1;
          end else begin
            case (nph_q)
              NP_BETWEEN, NP_LEAD: begin
                if (is_ws) begin
                  nph_d = NP_LEAD;
                end else if (rx_byte_i == fcp_pkg::CharPlus ||
                             rx_byte_i == fcp_pkg::CharMinus) begin
                  neg_d = (rx_byte_i == fcp_pkg::CharMinus);
                  nph_d = NP_DIGITS;
                end else if (is_digit) begin
                  acc_d = {4'd0, digit};
                  nph_d = NP_DIGITS;
                end else begin
                  nph_d = NP_TRAIL;
                end
              end
              NP_DIGITS: begin
                if (is_digit) begin
                  acc_d = 8'(acc_x10 + {4'd0, digit});
                end else begin
                  nph_d = NP_TRAIL;
                end
              end
              default: begin
              end
            endcase
          end
        end
        if (do_close && nph_q != NP_BETWEEN) begin
          if (fidx_q < FieldsFull) begin
            fields_d[fidx_q] = close_val;
            fidx_d           = fidx_q + 1'b1;
          end
          nph_d = NP_BETWEEN;
          neg_d = 1'b0;
          acc_d = '0;
        end
        body_len_d = body_len_q + 1'b1;
        if (body_len_d >= MaxBodyLen) begin
          phase_d = PH_FULL;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q      <= fcp_pkg::StartByteRst;
      end_q        <= fcp_pkg::EndByteRst;
      sep_q        <= fcp_pkg::SepByteRst;
      phase_q      <= PH_IDLE;
      body_len_q   <= '0;
      fidx_q       <= '0;
      nph_q        <= NP_BETWEEN;
      neg_q        <= 1'b0;
      acc_q        <= '0;
      ended_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          fcp_pkg::CFG_START_BYTE: start_q <= cfg_data_i;
          fcp_pkg::CFG_END_BYTE:   end_q   <= cfg_data_i;
          fcp_pkg::CFG_SEP_BYTE:   sep_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
      phase_q    <= phase_d;
      body_len_q <= body_len_d;
      fidx_q     <= fidx_d;
      nph_q      <= nph_d;
      neg_q      <= neg_d;
      acc_q      <= acc_d;
      ended_q    <= ended_d;
      if (skid_valid_q) begin
        if (out_pop) begin
          skid_valid_q <= 1'b0;
        end
      end else if (!out_valid_q || out_pop) begin
        out_valid_q <= res_valid;
      end else if (res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fields_q <= fields_d;
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_pop) begin
      out_q <= res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign motor_id_o    = out_q.values[0];
  assign motor_state_o = out_q.values[1];
  assign direction_o   = out_q.values[2];
  assign step_count_o  = out_q.values[3];
  assign speed_o       = out_q.values[4];

  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("Skid register holds an item while the output register is empty.");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (out_valid_q && !skid_valid_q))
    else $error("Skid item was not moved to the output register.");

  a_field_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fidx_q <= FieldsFull)
    else $error("Field index exceeds the field count.");

  a_full_body_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FULL) |-> (body_len_q >= MaxBodyLen))
    else $error("Parser awaits the end byte before the body is full.");

endmodule

`default_nettype wire
